@@ rtl/core/fjsp_pkg.sv @@
// Shared types and constants for the flat JSON string-map parser.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package fjsp_pkg;

	// result kinds
	localparam logic [2:0] KIND_KEY_BYTE = 3'd0;
	localparam logic [2:0] KIND_VAL_BYTE = 3'd1;
	localparam logic [2:0] KIND_KEY_END  = 3'd2;
	localparam logic [2:0] KIND_PAIR_END = 3'd3;
	localparam logic [2:0] KIND_OK       = 3'd4;
	localparam logic [2:0] KIND_EMPTY    = 3'd5;
	localparam logic [2:0] KIND_ERROR    = 3'd6;

	// burst queue depth between parser and serialiser
	localparam int FJSP_QUEUE_DEPTH = 4;

	// up to four results caused by one input byte, all of one kind
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      kind;
		logic [1:0]      last_idx;
	} burst_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/fjsp_front.sv @@
// Parser front end: accepts one document byte per cycle while in_fire is high and
// classifies it into a burst of up to four results. Depends on fjsp_pkg.
`default_nettype none

module fjsp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_eot,
	output fjsp_pkg::burst_t     push_ent,
	output logic                 push
);
	import fjsp_pkg::*;

	// parser phases
	localparam logic [3:0] PH_OPEN       = 4'd0;
	localparam logic [3:0] PH_AFTER_OPEN = 4'd1;
	localparam logic [3:0] PH_KEY        = 4'd2;
	localparam logic [3:0] PH_STRING     = 4'd3;
	localparam logic [3:0] PH_ESCAPE     = 4'd4;
	localparam logic [3:0] PH_HEX        = 4'd5;
	localparam logic [3:0] PH_BSLASH2    = 4'd6;
	localparam logic [3:0] PH_U2         = 4'd7;
	localparam logic [3:0] PH_HEX2       = 4'd8;
	localparam logic [3:0] PH_COLON      = 4'd9;
	localparam logic [3:0] PH_VALUE      = 4'd10;
	localparam logic [3:0] PH_AFTER_VAL  = 4'd11;

	// characters
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	// hex digit value, bit 4 flags a valid digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	// UTF-8 encoding of one code point, kind left at zero
	function automatic burst_t utf8_enc(input logic [20:0] cp);
		burst_t b;
		b = '0;
		if (cp[20:7] == '0) begin
			b.data[0]  = {1'b0, cp[6:0]};
			b.last_idx = 2'd0;
		end else if (cp[20:11] == '0) begin
			b.data[0]  = {3'b110, cp[10:6]};
			b.data[1]  = {2'b10, cp[5:0]};
			b.last_idx = 2'd1;
		end else if (cp[20:16] == '0) begin
			b.data[0]  = {4'b1110, cp[15:12]};
			b.data[1]  = {2'b10, cp[11:6]};
			b.data[2]  = {2'b10, cp[5:0]};
			b.last_idx = 2'd2;
		end else begin
			b.data[0]  = {5'b11110, cp[20:18]};
			b.data[1]  = {2'b10, cp[17:12]};
			b.data[2]  = {2'b10, cp[11:6]};
			b.data[3]  = {2'b10, cp[5:0]};
			b.last_idx = 2'd3;
		end
		return b;
	endfunction

	logic [3:0]  phase_q, phase_d;
	logic        in_value_q, in_value_d;
	logic [11:0] hex_acc_q, hex_acc_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [9:0]  high_sur_q, high_sur_d;
	logic        finished_q, finished_d;

	logic        has_res;
	logic        failed;
	burst_t      res;
	logic [4:0]  digit;
	logic [15:0] code;
	logic [20:0] pair_cp;

	assign digit   = hex_val(in_byte);
	assign code    = {hex_acc_q, digit[3:0]};
	assign pair_cp = 21'h10000 + {1'b0, high_sur_q, code[9:0]};

	// classify the byte and work out the next parser state
	always_comb begin
		phase_d    = phase_q;
		in_value_d = in_value_q;
		hex_acc_d  = hex_acc_q;
		hex_cnt_d  = hex_cnt_q;
		high_sur_d = high_sur_q;
		finished_d = finished_q;
		has_res    = 1'b0;
		failed     = 1'b0;
		res        = '0;

		if (!finished_q) begin
			unique case (phase_q)
				PH_OPEN: begin
					if (in_byte == CH_LBRACE)
						phase_d = PH_AFTER_OPEN;
					else if (!is_space(in_byte))
						failed = 1'b1;
				end
				PH_AFTER_OPEN, PH_KEY: begin
					if (is_space(in_byte)) begin
						// skip
					end else if (in_byte == CH_RBRACE && phase_q == PH_AFTER_OPEN) begin
						has_res    = 1'b1;
						res.kind   = KIND_EMPTY;
						finished_d = 1'b1;
					end else if (in_byte == CH_QUOTE) begin
						in_value_d = 1'b0;
						phase_d    = PH_STRING;
					end else begin
						failed = 1'b1;
					end
				end
				PH_STRING: begin
					if (in_byte == CH_QUOTE) begin
						has_res = 1'b1;
						if (in_value_q) begin
							res.kind   = KIND_PAIR_END;
							in_value_d = 1'b0;
							phase_d    = PH_AFTER_VAL;
						end else begin
							res.kind = KIND_KEY_END;
							phase_d  = PH_COLON;
						end
					end else if (in_byte == CH_BSLASH) begin
						phase_d = PH_ESCAPE;
					end else begin
						has_res     = 1'b1;
						res.data[0] = in_byte;
						res.kind    = {2'b00, in_value_q};
					end
				end
				PH_ESCAPE: begin
					phase_d     = PH_STRING;
					res.kind    = {2'b00, in_value_q};
					has_res     = 1'b1;
					case (in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: res.data[0] = in_byte;
						CH_LOW_N: res.data[0] = CH_LF;
						CH_LOW_T: res.data[0] = CH_TAB;
						CH_LOW_R: res.data[0] = CH_CR;
						CH_LOW_B: res.data[0] = CH_BS;
						CH_LOW_F: res.data[0] = CH_FF;
						CH_LOW_U: begin
							has_res   = 1'b0;
							hex_acc_d = '0;
							hex_cnt_d = '0;
							phase_d   = PH_HEX;
						end
						default: begin
							has_res = 1'b0;
							failed  = 1'b1;
						end
					endcase
				end
				PH_HEX, PH_HEX2: begin
					if (!digit[4]) begin
						failed = 1'b1;
					end else if (hex_cnt_q != 2'd3) begin
						hex_acc_d = code[11:0];
						hex_cnt_d = hex_cnt_q + 2'd1;
					end else begin
						hex_acc_d = '0;
						hex_cnt_d = '0;
						if (phase_q == PH_HEX) begin
							if (code[15:10] == 6'b110110) begin
								// high surrogate: wait for its partner
								high_sur_d = code[9:0];
								phase_d    = PH_BSLASH2;
							end else begin
								phase_d  = PH_STRING;
								has_res  = 1'b1;
								res      = utf8_enc({5'd0, code});
								res.kind = {2'b00, in_value_q};
							end
						end else if (code[15:10] != 6'b110111) begin
							failed = 1'b1;
						end else begin
							phase_d    = PH_STRING;
							high_sur_d = '0;
							has_res    = 1'b1;
							res        = utf8_enc(pair_cp);
							res.kind   = {2'b00, in_value_q};
						end
					end
				end
				PH_BSLASH2: begin
					if (in_byte == CH_BSLASH)
						phase_d = PH_U2;
					else
						failed = 1'b1;
				end
				PH_U2: begin
					if (in_byte == CH_LOW_U) begin
						hex_acc_d = '0;
						hex_cnt_d = '0;
						phase_d   = PH_HEX2;
					end else begin
						failed = 1'b1;
					end
				end
				PH_COLON: begin
					if (in_byte == CH_COLON)
						phase_d = PH_VALUE;
					else if (!is_space(in_byte))
						failed = 1'b1;
				end
				PH_VALUE: begin
					if (in_byte == CH_QUOTE) begin
						in_value_d = 1'b1;
						phase_d    = PH_STRING;
					end else if (!is_space(in_byte)) begin
						failed = 1'b1;
					end
				end
				PH_AFTER_VAL: begin
					if (is_space(in_byte)) begin
						// skip
					end else if (in_byte == CH_COMMA) begin
						phase_d = PH_KEY;
					end else if (in_byte == CH_RBRACE) begin
						has_res    = 1'b1;
						res.kind   = KIND_OK;
						finished_d = 1'b1;
					end else begin
						failed = 1'b1;
					end
				end
				default: failed = 1'b1;
			endcase

			// an error, or text ending before the document closes, stands alone
			if (failed || (in_eot && !finished_d)) begin
				has_res    = 1'b1;
				res        = '0;
				res.kind   = KIND_ERROR;
				finished_d = 1'b1;
			end
		end

		// end of text: return to the initial state
		if (in_eot) begin
			phase_d    = PH_OPEN;
			in_value_d = 1'b0;
			hex_acc_d  = '0;
			hex_cnt_d  = '0;
			high_sur_d = '0;
			finished_d = 1'b0;
		end
	end

	assign push     = in_fire && has_res;
	assign push_ent = res;

	// advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPEN;
			in_value_q <= 1'b0;
			hex_acc_q  <= '0;
			hex_cnt_q  <= '0;
			high_sur_q <= '0;
			finished_q <= 1'b0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			in_value_q <= in_value_d;
			hex_acc_q  <= hex_acc_d;
			hex_cnt_q  <= hex_cnt_d;
			high_sur_q <= high_sur_d;
			finished_q <= finished_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/fjsp_queue.sv @@
// Short burst queue between parser front end and output serialiser.
// Depends on fjsp_pkg for the burst and status types.
`default_nettype none

module fjsp_queue #(
	parameter int DEPTH = fjsp_pkg::FJSP_QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fjsp_pkg::burst_t    push_ent,
	input  wire logic                pop,
	output fjsp_pkg::burst_t         head,
	output fjsp_pkg::q_status_t      stat
);
	import fjsp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	burst_t        slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slots_q[rd_ptr_q];

	// store incoming burst
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_ent;
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/fjsp_back.sv @@
// Output serialiser: drains each queued burst one result per cycle, while the
// output is not stalled, into a registered output stage. Depends on fjsp_pkg.
`default_nettype none

module fjsp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fjsp_pkg::burst_t    head,
	input  wire fjsp_pkg::q_status_t stat,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               out_byte,
	output logic [2:0]               out_kind,
	output logic                     out_last
);
	import fjsp_pkg::*;

	logic       vld_q;
	logic [1:0] idx_q;
	logic [7:0] byte_q;
	logic [2:0] kind_q;
	logic       last_q;
	logic       load;
	logic       at_last;

	assign load    = !stat.empty && (!vld_q || out_ready);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	// output valid and burst position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.data[idx_q];
			kind_q <= head.kind;
			last_q <= at_last;
		end
	end

	assign out_valid = vld_q;
	assign out_byte  = byte_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

@@ rtl/core/flat_json_string_map_parser_top.sv @@
// Top level of the flat JSON string-map parser: front end, burst queue and
// output serialiser. Depends on fjsp_pkg, fjsp_front, fjsp_queue, fjsp_back.
//
//  channel | dir | tdata          | tuser          | tlast
//  s_*     | in  | [7:0] in_byte  | -              | end_of_text
//  m_*     | out | [7:0] out_byte | [2:0] out_kind | last_of_run
//
// A byte is accepted in any cycle the burst queue has room; the parser state
// advances once per byte. Each byte yields zero to four results, which the
// serialiser sends at one per cycle while the output is not stalled; each
// burst is written into the queue when its byte is accepted, and its results
// leave through the registered output stage. Reset clears parser state, queue
// pointers and output valid at once. A stalled output backs up into the queue,
// then drops s_tready.
`default_nettype none

module flat_json_string_map_parser_top #(
	parameter int QUEUE_DEPTH = fjsp_pkg::FJSP_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // end_of_text
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic [2:0]      m_tuser,   // [2:0] out_kind
	output logic            m_tlast    // last_of_run
);
	import fjsp_pkg::*;

	burst_t    push_ent;
	burst_t    head;
	q_status_t stat;
	logic      push;
	logic      pop;
	logic      in_fire;

	assign s_tready = !stat.full;
	assign in_fire  = s_tvalid && s_tready;

	fjsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_byte  (s_tdata),
		.in_eot   (s_tlast),
		.push_ent (push_ent),
		.push     (push)
	);

	fjsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	fjsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

	// markers and status results are single, carry no byte
	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_KEY_END || m_tuser == KIND_PAIR_END ||
		 m_tuser == KIND_OK || m_tuser == KIND_EMPTY || m_tuser == KIND_ERROR))
		|-> (m_tlast && m_tdata == 8'd0))
		else $error("marker result not alone or carries a byte");

	// no kind code beyond error ever leaves
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 3'd7))
		else $error("undefined result kind");

	// queue cannot be full and empty together
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue status inconsistent");

	// a burst is only popped when the output stage takes its final result
	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (m_tvalid && m_tlast))
		else $error("burst popped without its final result");

endmodule

`default_nettype wire
